// ===== rtl/mfhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhc_pkg
// Shared types and constants for the module file header checker.
// ----------------------------------------------------------------------------
package mfhc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BytesW = 3;

  localparam logic [WordW-1:0] TAG_WORD    = 32'd0;
  localparam logic [WordW-1:0] VTYPE_WORD  = 32'd4;
  localparam logic [WordW-1:0] LENGTH_WORD = 32'd8;
  localparam logic [WordW-1:0] SKIP_WORD   = 32'd11;
  localparam logic [WordW-1:0] TAG_MAX     = 32'd10;
  localparam logic [WordW-1:0] VTYPE_MAX   = 32'd3;
  localparam logic [WordW-1:0] TAG_NEED    = 32'h4;
  localparam logic [WordW-1:0] VTYPE_NEED  = 32'h14;
  localparam logic [WordW-1:0] MIN_FILE    = 32'h30;
  localparam logic [WordW-1:0] SAT_VALUE   = 32'hFFFF_FFFF;

  localparam logic [BytesW-1:0] FULL_WORD_BYTES = 3'd4;

  typedef enum logic [2:0] {
    FAIL_NONE     = 3'd0,
    FAIL_TAG      = 3'd1,
    FAIL_VTYPE    = 3'd2,
    FAIL_LENGTH   = 3'd3,
    FAIL_CHECKSUM = 3'd4
  } failure_e;

  typedef struct packed {
    logic [WordW-1:0]  file_word;
    logic [BytesW-1:0] bytes_in_word;
    logic              last_word;
  } item_t;

  typedef struct packed {
    logic             file_accepted;
    logic [2:0]       failure_code;
    logic [WordW-1:0] computed_checksum;
  } result_t;

endpackage

// ===== rtl/mfhc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhc_if
// Valid/ready channels for file words and verdicts.
// ----------------------------------------------------------------------------
interface mfhc_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_word;
  logic [2:0]  bytes_in_word;
  logic        last_word;

  modport source (output valid, output file_word, output bytes_in_word,
                  output last_word, input ready);
  modport sink   (input valid, input file_word, input bytes_in_word,
                  input last_word, output ready);
endinterface

interface mfhc_result_if;
  logic        valid;
  logic        ready;
  logic        file_accepted;
  logic [2:0]  failure_code;
  logic [31:0] computed_checksum;

  modport source (output valid, output file_accepted, output failure_code,
                  output computed_checksum, input ready);
  modport sink   (input valid, input file_accepted, input failure_code,
                  input computed_checksum, output ready);
endinterface

// ===== rtl/mfhc_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhc_in_reg
// Input register stage holding one accepted item.
// ----------------------------------------------------------------------------
module mfhc_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  mfhc_pkg::item_t in_item_i,
  output logic           in_ready_o,
  input  logic           take_i,
  output logic           s1_valid_o,
  output mfhc_pkg::item_t s1_item_o
);

  logic            valid_q;
  mfhc_pkg::item_t item_q;
  logic            accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_item_o  = item_q;

endmodule

// ===== rtl/mfhc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhc_core
// Running sum, byte count and header flags; forms the verdict on the last item.
// ----------------------------------------------------------------------------
module mfhc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s1_valid_i,
  input  mfhc_pkg::item_t  s1_item_i,
  input  logic             out_free_i,
  output logic             take_o,
  output logic             res_load_o,
  output mfhc_pkg::result_t res_o
);

  logic [31:0] pos_q, pos_d, pos_n;
  logic [31:0] bt_q, bt_d, bt_n;
  logic [31:0] sum_q, sum_d, sum_n;
  logic        tag_q, tag_d, tag_n;
  logic        vtype_q, vtype_d, vtype_n;
  logic [31:0] len_q, len_d, len_n;
  logic [31:0] cks_q, cks_d, cks_n;

  logic [2:0]  nb;
  logic [32:0] bt_sum;
  logic [31:0] w;
  logic [31:0] cks;
  mfhc_pkg::failure_e code;

  assign w          = s1_item_i.file_word;
  assign take_o     = s1_valid_i && (!s1_item_i.last_word || out_free_i);
  assign res_load_o = take_o && s1_item_i.last_word;

  always_comb begin
    nb = (s1_item_i.bytes_in_word > mfhc_pkg::FULL_WORD_BYTES) ?
         mfhc_pkg::FULL_WORD_BYTES : s1_item_i.bytes_in_word;

    tag_n   = (pos_q == mfhc_pkg::TAG_WORD) ?
              (w >= 32'd1 && w <= mfhc_pkg::TAG_MAX) : tag_q;
    vtype_n = (pos_q == mfhc_pkg::VTYPE_WORD) ?
              (w >= 32'd1 && w <= mfhc_pkg::VTYPE_MAX) : vtype_q;
    len_n   = (pos_q == mfhc_pkg::LENGTH_WORD) ? w : len_q;
    cks_n   = (pos_q == mfhc_pkg::SKIP_WORD) ? w : cks_q;

    sum_n = (nb == mfhc_pkg::FULL_WORD_BYTES && pos_q != mfhc_pkg::SKIP_WORD) ?
            sum_q + w : sum_q;

    bt_sum = {1'b0, bt_q} + {30'd0, nb};
    bt_n   = bt_sum[32] ? mfhc_pkg::SAT_VALUE : bt_sum[31:0];
    pos_n  = (pos_q == mfhc_pkg::SAT_VALUE) ? pos_q : pos_q + 32'd1;

    cks = 32'd0 - sum_n;
    if (bt_n >= mfhc_pkg::TAG_NEED && !tag_n) begin
      code = mfhc_pkg::FAIL_TAG;
    end else if (bt_n >= mfhc_pkg::VTYPE_NEED && !vtype_n) begin
      code = mfhc_pkg::FAIL_VTYPE;
    end else if (bt_n < mfhc_pkg::MIN_FILE || bt_n != len_n) begin
      code = mfhc_pkg::FAIL_LENGTH;
    end else if (cks != cks_n) begin
      code = mfhc_pkg::FAIL_CHECKSUM;
    end else begin
      code = mfhc_pkg::FAIL_NONE;
    end

    res_o.file_accepted     = (code == mfhc_pkg::FAIL_NONE);
    res_o.failure_code      = code;
    res_o.computed_checksum = cks;

    pos_d   = pos_q;
    bt_d    = bt_q;
    sum_d   = sum_q;
    tag_d   = tag_q;
    vtype_d = vtype_q;
    len_d   = len_q;
    cks_d   = cks_q;
    if (take_o) begin
      if (s1_item_i.last_word) begin
        // verdict given, start the next file from scratch
        pos_d   = '0;
        bt_d    = '0;
        sum_d   = '0;
        tag_d   = 1'b0;
        vtype_d = 1'b0;
        len_d   = '0;
        cks_d   = '0;
      end else begin
        pos_d   = pos_n;
        bt_d    = bt_n;
        sum_d   = sum_n;
        tag_d   = tag_n;
        vtype_d = vtype_n;
        len_d   = len_n;
        cks_d   = cks_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bt_q    <= '0;
      sum_q   <= '0;
      tag_q   <= 1'b0;
      vtype_q <= 1'b0;
      len_q   <= '0;
      cks_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      bt_q    <= bt_d;
      sum_q   <= sum_d;
      tag_q   <= tag_d;
      vtype_q <= vtype_d;
      len_q   <= len_d;
      cks_q   <= cks_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |=> (pos_q == '0 && bt_q == '0 && sum_q == '0))
    else $error("state not cleared after verdict");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && !s1_item_i.last_word && pos_q != mfhc_pkg::SAT_VALUE)
    |=> pos_q == $past(pos_q) + 32'd1)
    else $error("word position did not advance");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_o |=> ($stable(sum_q) && $stable(bt_q) && $stable(pos_q)))
    else $error("state changed without an item");

  a_load_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |-> out_free_i)
    else $error("verdict loaded into a full output register");

endmodule

// ===== rtl/mfhc_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhc_out_reg
// Result register holding one verdict until it is taken.
// ----------------------------------------------------------------------------
module mfhc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mfhc_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mfhc_pkg::result_t out_res_o
);

  logic              valid_q;
  mfhc_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== rtl/module_file_header_checker_core.sv =====
`timescale 1ns / 1ps
// a verdict enters the result register as the core takes the file's last item
// throughput: one word per cycle while the result register can take each verdict
// the input register takes a new item while a verdict waits, unless it holds a last word
// reset: asynchronous, active low; clears the file state and both valid flags
// no clearing pass; the block accepts items as soon as it leaves reset
// ----------------------------------------------------------------------------
// module_file_header_checker_core
// Checks the header fields and word-sum checksum of a file given word by word.
// ----------------------------------------------------------------------------
module module_file_header_checker_core (
  input  logic clk_i,
  input  logic rst_ni,
  mfhc_item_if.sink     item_i,
  mfhc_result_if.source result_o
);

  mfhc_pkg::item_t   in_item;
  mfhc_pkg::item_t   s1_item;
  mfhc_pkg::result_t core_res;
  mfhc_pkg::result_t out_res;
  logic              s1_valid;
  logic              take;
  logic              res_load;
  logic              out_free;

  assign in_item.file_word     = item_i.file_word;
  assign in_item.bytes_in_word = item_i.bytes_in_word;
  assign in_item.last_word     = item_i.last_word;

  mfhc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_item_i  (in_item),
    .in_ready_o (item_i.ready),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  mfhc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_item_i  (s1_item),
    .out_free_i (out_free),
    .take_o     (take),
    .res_load_o (res_load),
    .res_o      (core_res)
  );

  mfhc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (core_res),
    .free_o      (out_free),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_res_o   (out_res)
  );

  assign result_o.file_accepted     = out_res.file_accepted;
  assign result_o.failure_code      = out_res.failure_code;
  assign result_o.computed_checksum = out_res.computed_checksum;

endmodule

// ===== tb/mfhc_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhc_verdict_checker
// Watches the word and verdict channels of the file header checker. It keeps
// its own copy of the per-file state and works out the verdict of each file
// from the words taken. Each verdict that leaves the block is compared field
// by field with the oldest one predicted.
// ----------------------------------------------------------------------------
module mfhc_verdict_checker
  import mfhc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  mfhc_item_if              item_mon,
  mfhc_result_if            res_mon,
  output int                fail_cnt_o,
  output int                pending_o,
  output logic [4:0][15:0]  verdict_cnt_o
);

  logic [WordW-1:0] word_pos_q  = '0;
  logic [WordW-1:0] byte_cnt_q  = '0;
  logic [WordW-1:0] word_sum_q  = '0;
  logic [WordW-1:0] rep_len_q   = '0;
  logic [WordW-1:0] stored_cks_q = '0;
  logic             tag_ok_q    = 1'b0;
  logic             vtype_ok_q  = 1'b0;

  result_t verdict_q[$];

  initial begin
    fail_cnt_o    = 0;
    pending_o     = 0;
    verdict_cnt_o = '0;
  end

  always @(posedge clk_i) begin : track
    logic [WordW-1:0] word;
    logic [WordW-1:0] nbytes;
    logic [WordW-1:0] cks;
    failure_e         code;
    result_t          want;
    if (rst_ni) begin
      if (item_mon.valid && item_mon.ready) begin
        word   = item_mon.file_word;
        nbytes = (item_mon.bytes_in_word > FULL_WORD_BYTES) ? WordW'(FULL_WORD_BYTES)
                                                            : WordW'(item_mon.bytes_in_word);
        if (word_pos_q == TAG_WORD) begin
          tag_ok_q = (word != '0) && (word <= TAG_MAX);
        end else if (word_pos_q == VTYPE_WORD) begin
          vtype_ok_q = (word != '0) && (word <= VTYPE_MAX);
        end else if (word_pos_q == LENGTH_WORD) begin
          rep_len_q = word;
        end else if (word_pos_q == SKIP_WORD) begin
          stored_cks_q = word;
        end
        if (nbytes == WordW'(FULL_WORD_BYTES) && word_pos_q != SKIP_WORD) begin
          word_sum_q = word_sum_q + word;
        end
        byte_cnt_q = (byte_cnt_q > SAT_VALUE - nbytes) ? SAT_VALUE : byte_cnt_q + nbytes;
        if (word_pos_q != SAT_VALUE) begin
          word_pos_q = word_pos_q + 1'b1;
        end
        if (item_mon.last_word) begin
          cks = '0 - word_sum_q;
          if (byte_cnt_q >= TAG_NEED && !tag_ok_q) begin
            code = FAIL_TAG;
          end else if (byte_cnt_q >= VTYPE_NEED && !vtype_ok_q) begin
            code = FAIL_VTYPE;
          end else if (byte_cnt_q < MIN_FILE || byte_cnt_q != rep_len_q) begin
            code = FAIL_LENGTH;
          end else if (cks != stored_cks_q) begin
            code = FAIL_CHECKSUM;
          end else begin
            code = FAIL_NONE;
          end
          want.file_accepted     = (code == FAIL_NONE);
          want.failure_code      = code;
          want.computed_checksum = cks;
          verdict_q.push_back(want);
          word_pos_q   = '0;
          byte_cnt_q   = '0;
          word_sum_q   = '0;
          rep_len_q    = '0;
          stored_cks_q = '0;
          tag_ok_q     = 1'b0;
          vtype_ok_q   = 1'b0;
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        if (res_mon.failure_code <= FAIL_CHECKSUM) begin
          verdict_cnt_o[res_mon.failure_code] = verdict_cnt_o[res_mon.failure_code] + 1'b1;
        end
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict with none expected, code %0d checksum %h", $time,
                   res_mon.failure_code, res_mon.computed_checksum);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          want = verdict_q.pop_front();
          if (res_mon.file_accepted !== want.file_accepted) begin
            $display("%0t: file_accepted mismatch, expected %0b actual %0b", $time,
                     want.file_accepted, res_mon.file_accepted);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (res_mon.failure_code !== want.failure_code) begin
            $display("%0t: failure_code mismatch, expected %0d actual %0d", $time,
                     want.failure_code, res_mon.failure_code);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (res_mon.computed_checksum !== want.computed_checksum) begin
            $display("%0t: computed_checksum mismatch, expected %h actual %h", $time,
                     want.computed_checksum, res_mon.computed_checksum);
            fail_cnt_o = fail_cnt_o + 1;
          end
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives files into the module file header checker: a few directed files on
// the edges of the header checks, a burst of one-word files against a long
// stall of the verdict side, then random files that are well formed or carry
// one flaw or random noise. Both sides idle at random. The checker beside
// the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import mfhc_pkg::*;

  localparam int unsigned LimitCycles = 200_000;
  localparam int unsigned RandomWords = 800;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned MaxGap      = 16;
  localparam int unsigned DrainCycles = 8;

  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_TAG,
    FLAW_VTYPE,
    FLAW_LENGTH,
    FLAW_CHECKSUM,
    FLAW_WIDE_COUNT,
    FLAW_ZERO_COUNT,
    FLAW_MID_PARTIAL,
    FLAW_DIRTY_TAIL,
    FLAW_NOISE
  } flaw_e;

  logic clk_i;
  logic rst_ni;

  mfhc_item_if   item_if ();
  mfhc_result_if res_if ();

  int              fail_cnt;
  int              pending;
  logic [4:0][15:0] verdict_cnt;

  item_t       file_q[$];
  int unsigned words_sent = 0;
  int unsigned files_sent = 0;
  int unsigned cycles = 0;
  bit          tx_calm   = 1'b0;
  bit          tx_rush   = 1'b0;
  bit          rx_calm   = 1'b0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;

  module_file_header_checker_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if)
  );

  mfhc_verdict_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_mon      (item_if),
    .res_mon       (res_if),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .verdict_cnt_o (verdict_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LimitCycles) begin
      $display("module_file_header_checker_core test failed");
      $finish;
    end
  end

  task automatic add_word(logic [31:0] word, logic [2:0] nbytes, logic last);
    item_t it;
    it.file_word     = word;
    it.bytes_in_word = nbytes;
    it.last_word     = last;
    file_q.push_back(it);
  endtask

  // file of nbytes bytes; its length and checksum words match where the file reaches them
  task automatic build_file(int unsigned nbytes, logic [31:0] tag, logic [31:0] vtype);
    int unsigned nwords;
    int unsigned tail;
    logic [31:0] sum;
    item_t       it;
    file_q.delete();
    nwords = (nbytes + 3) / 4;
    tail   = nbytes % 4;
    sum    = '0;
    for (int unsigned i = 0; i < nwords; i++) begin
      it.file_word     = $urandom;
      it.bytes_in_word = FULL_WORD_BYTES;
      it.last_word     = (i == nwords - 1);
      if (i == TAG_WORD) it.file_word = tag;
      if (i == VTYPE_WORD) it.file_word = vtype;
      if (i == LENGTH_WORD) it.file_word = nbytes;
      if (it.last_word && tail != 0) begin
        it.bytes_in_word = 3'(tail);
        it.file_word     = it.file_word & ((32'h1 << (8 * tail)) - 1);
      end
      if (i != SKIP_WORD && it.bytes_in_word == FULL_WORD_BYTES) sum = sum + it.file_word;
      file_q.push_back(it);
    end
    if (nwords > SKIP_WORD) file_q[SKIP_WORD].file_word = '0 - sum;
  endtask

  task automatic put_word(item_t it);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    gap = (tx_calm || tx_rush) ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.file_word     <= it.file_word;
    item_if.bytes_in_word <= it.bytes_in_word;
    item_if.last_word     <= it.last_word;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) put_word(file_q[i]);
    file_q.delete();
    files_sent++;
  endtask

  // verdict side: random stalls, one long hold while the burst goes in
  initial begin : drain
    int unsigned gap;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, MaxGap);
      if (hold_req && !hold_done) begin
        gap       = HoldCycles;
        hold_done = 1'b1;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(res_if.valid && res_if.ready)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    flaw_e       flaw;
    int unsigned nbytes;
    int unsigned k;
    item_if.valid         = 1'b0;
    item_if.file_word     = '0;
    item_if.bytes_in_word = '0;
    item_if.last_word     = 1'b0;
    rst_ni                = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // one-word files: bad tag, too short for the tag check, zero and wide counts
    add_word(32'hFFFF_FFFF, FULL_WORD_BYTES, 1'b1);
    send_file();
    add_word(32'h0, 3'd1, 1'b1);
    send_file();
    add_word(32'h0, 3'd0, 1'b1);
    send_file();
    add_word(32'h5, 3'd7, 1'b1);
    send_file();
    // bad version type in a short file, then the smallest good file
    build_file(VTYPE_NEED, 32'd1, 32'd0);
    send_file();
    build_file(MIN_FILE, TAG_MAX, VTYPE_MAX);
    send_file();

    // back-to-back one-word files while the verdict side holds off
    hold_req = 1'b1;
    tx_rush  = 1'b1;
    repeat (8) begin
      add_word($urandom, 3'($urandom_range(1, 4)), 1'b1);
      send_file();
    end
    tx_rush = 1'b0;

    while (words_sent < RandomWords) begin
      case ($urandom_range(0, 19))
        0, 1:    nbytes = $urandom_range(1, MIN_FILE - 1);
        2:       nbytes = $urandom_range(MIN_FILE, 256);
        default: nbytes = $urandom_range(MIN_FILE, 96);
      endcase
      build_file(nbytes, $urandom_range(1, TAG_MAX), $urandom_range(1, VTYPE_MAX));
      flaw = ($urandom_range(0, 1) == 0) ? FLAW_NONE : flaw_e'($urandom_range(1, FLAW_NOISE));
      if (nbytes < MIN_FILE && flaw != FLAW_NOISE && flaw != FLAW_DIRTY_TAIL) flaw = FLAW_NONE;
      k = (file_q.size() > 1) ? $urandom_range(0, file_q.size() - 2) : 0;
      case (flaw)
        FLAW_TAG: begin
          case ($urandom_range(0, 2))
            0:       file_q[TAG_WORD].file_word = '0;
            1:       file_q[TAG_WORD].file_word = TAG_MAX + 1;
            default: file_q[TAG_WORD].file_word = $urandom;
          endcase
        end
        FLAW_VTYPE: begin
          case ($urandom_range(0, 2))
            0:       file_q[VTYPE_WORD].file_word = '0;
            1:       file_q[VTYPE_WORD].file_word = VTYPE_MAX + 1;
            default: file_q[VTYPE_WORD].file_word = $urandom;
          endcase
        end
        FLAW_LENGTH:
          file_q[LENGTH_WORD].file_word ^= 32'h1 << $urandom_range(0, 31);
        FLAW_CHECKSUM:
          file_q[SKIP_WORD].file_word ^= 32'h1 << $urandom_range(0, 31);
        FLAW_WIDE_COUNT:
          file_q[k].bytes_in_word = 3'($urandom_range(5, 7));
        FLAW_ZERO_COUNT:
          file_q[k].bytes_in_word = 3'd0;
        FLAW_MID_PARTIAL:
          file_q[k].bytes_in_word = 3'($urandom_range(1, 3));
        FLAW_DIRTY_TAIL: begin
          file_q[file_q.size() - 1].bytes_in_word = 3'($urandom_range(1, 3));
          file_q[file_q.size() - 1].file_word     = $urandom;
        end
        FLAW_NOISE: begin
          foreach (file_q[i]) begin
            file_q[i].file_word     = $urandom;
            file_q[i].bytes_in_word = 3'($urandom_range(0, 7));
          end
        end
        default: ;
      endcase
      send_file();
    end

    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d words in %0d files, one long verdict stall included",
             words_sent, files_sent);
    $display("verdicts seen: ok %0d, tag %0d, version %0d, length %0d, checksum %0d",
             verdict_cnt[FAIL_NONE], verdict_cnt[FAIL_TAG], verdict_cnt[FAIL_VTYPE],
             verdict_cnt[FAIL_LENGTH], verdict_cnt[FAIL_CHECKSUM]);
    if (fail_cnt == 0) begin
      $display("module_file_header_checker_core test passed");
    end else begin
      $display("module_file_header_checker_core test failed");
    end
    $finish;
  end

endmodule
